FILE: src/lpaw_pkg.sv
package lpaw_pkg;

  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_PAGES   = 8;

  // compare widths wide enough to hold the screen limits themselves
  localparam int unsigned WIDTH_CMP_W = 9;
  localparam int unsigned PAGES_CMP_W = 5;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_PAGES   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMN = 4'd3;

  localparam logic [7:0] CMD_START_LINE = 8'h40;
  localparam logic [7:0] CMD_PAGE_ADDR  = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
  localparam logic [7:0] CMD_COL_LOW    = 8'h00;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'hAF;

  // output slots of one item, in emission order
  localparam int unsigned SLOT_START  = 0;
  localparam int unsigned SLOT_PAGE   = 1;
  localparam int unsigned SLOT_COL_HI = 2;
  localparam int unsigned SLOT_COL_LO = 3;
  localparam int unsigned SLOT_DATA   = 4;
  localparam int unsigned SLOT_DONE   = 5;
  localparam int unsigned NUM_SLOTS   = 6;

  typedef struct packed {
    logic [7:0] area_width;
    logic [3:0] area_pages;
    logic [2:0] start_page;
    logic [6:0] start_column;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           pixel;
    logic [7:0]           page_cmd;
    logic [7:0]           col_hi_cmd;
    logic [7:0]           col_lo_cmd;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       area_done;
    logic       last;
  } result_t;

endpackage

FILE: src/lcd_page_area_writer.sv
// channel | direction | handshake                   | payload
// s_axis  | in        | s_axis_tvalid_i/tready_o    | tdata: pixel_byte
// m_axis  | out       | m_axis_tvalid_o/tready_i    | tdata: out_byte, tuser: is_data,
//         |           |                             | area_done, tlast: last
// cfg     | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one item per cycle while items fall inside a page and the output is not stalled:
// each makes one data byte. a page's first item makes 4 bytes (5 on the first page,
// one more for the closing 0xaf); the item register drains one byte per cycle unless stalled.
// reset returns the area registers to a full 128 x 8 screen and counters to 0.
// a stalled output holds the result register, the item register fills behind it.
module lcd_page_area_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] pixel_byte
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0]                      m_axis_tuser_o,  // [0] is_data, [1] area_done
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpaw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpaw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpaw_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    in_accept;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  lpaw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpaw_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (in_accept),
    .pixel_i  (s_axis_tdata_i),
    .item_o   (item)
  );

  lpaw_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = res.out_byte;
  assign m_axis_tuser_o = {res.area_done, res.is_data};
  assign m_axis_tlast_o = res.last;

endmodule

FILE: src/lpaw_cfg_regs.sv
module lpaw_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lpaw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lpaw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lpaw_pkg::cfg_t                   cfg_o
);
  import lpaw_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AREA_WIDTH:   cfg_d.area_width   = cfg_data_i[7:0];
        CFG_AREA_PAGES:   cfg_d.area_pages   = cfg_data_i[3:0];
        CFG_START_PAGE:   cfg_d.start_page   = cfg_data_i[2:0];
        CFG_START_COLUMN: cfg_d.start_column = cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_width   <= 8'd128;
      cfg_q.area_pages   <= 4'd8;
      cfg_q.start_page   <= 3'd0;
      cfg_q.start_column <= 7'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/lpaw_sequencer.sv
module lpaw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lpaw_pkg::cfg_t  cfg_i,
  input  logic            accept_i,
  input  logic [7:0]      pixel_i,
  output lpaw_pkg::item_t item_o
);
  import lpaw_pkg::*;

  localparam logic [WIDTH_CMP_W-1:0] MaxWidth = WIDTH_CMP_W'(SCREEN_COLUMNS);
  localparam logic [PAGES_CMP_W-1:0] MaxPages = PAGES_CMP_W'(SCREEN_PAGES);

  logic [7:0] column_q, column_d;
  logic [3:0] page_q, page_d;

  logic [WIDTH_CMP_W-1:0] width_eff, column_next;
  logic [PAGES_CMP_W-1:0] pages_eff, page_next;
  logic                   page_end, area_end;
  logic [3:0]             page_addr;

  always_comb begin
    // clamp the area to what the screen holds, zero acts as one
    width_eff = {1'b0, cfg_i.area_width};
    if (width_eff == '0)     width_eff = WIDTH_CMP_W'(1);
    if (width_eff > MaxWidth) width_eff = MaxWidth;
    pages_eff = {1'b0, cfg_i.area_pages};
    if (pages_eff == '0)     pages_eff = PAGES_CMP_W'(1);
    if (pages_eff > MaxPages) pages_eff = MaxPages;

    column_next = {1'b0, column_q} + WIDTH_CMP_W'(1);
    page_next   = {1'b0, page_q} + PAGES_CMP_W'(1);
    page_end    = (column_next >= width_eff);
    area_end    = page_end && (page_next >= pages_eff);

    page_addr = {1'b0, cfg_i.start_page} + page_q;

    item_o.slots              = '0;
    item_o.slots[SLOT_START]  = (column_q == '0) && (page_q == '0);
    item_o.slots[SLOT_PAGE]   = (column_q == '0);
    item_o.slots[SLOT_COL_HI] = (column_q == '0);
    item_o.slots[SLOT_COL_LO] = (column_q == '0);
    item_o.slots[SLOT_DATA]   = 1'b1;
    item_o.slots[SLOT_DONE]   = area_end;
    item_o.pixel      = pixel_i;
    item_o.page_cmd   = CMD_PAGE_ADDR | {4'h0, page_addr};
    item_o.col_hi_cmd = CMD_COL_HIGH | {5'h00, cfg_i.start_column[6:4]};
    item_o.col_lo_cmd = CMD_COL_LOW | {4'h0, cfg_i.start_column[3:0]};

    column_d = column_q;
    page_d   = page_q;
    if (accept_i) begin
      if (page_end) begin
        column_d = '0;
        page_d   = area_end ? 4'd0 : page_next[3:0];
      end else begin
        column_d = column_next[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      page_q   <= '0;
    end else begin
      column_q <= column_d;
      page_q   <= page_d;
    end
  end

endmodule

FILE: src/lpaw_emitter.sv
module lpaw_emitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpaw_pkg::item_t   item_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output lpaw_pkg::result_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import lpaw_pkg::*;

  item_t   item_q, item_d;
  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;

  logic                 item_busy, res_load, take, final_slot, in_accept;
  logic [NUM_SLOTS-1:0] pick, rest;

  always_comb begin
    item_busy  = |item_q.slots;
    // lowest pending slot goes out first
    pick       = item_q.slots & (~item_q.slots + NUM_SLOTS'(1));
    rest       = item_q.slots & ~pick;
    final_slot = (rest == '0);
    res_load   = !res_valid_q || res_ready_i;
    take       = item_busy && res_load;
    in_ready_o = !item_busy || (take && final_slot);
    in_accept  = in_valid_i && in_ready_o;

    res_d.out_byte = ({8{pick[SLOT_START]}}  & CMD_START_LINE)
                   | ({8{pick[SLOT_PAGE]}}   & item_q.page_cmd)
                   | ({8{pick[SLOT_COL_HI]}} & item_q.col_hi_cmd)
                   | ({8{pick[SLOT_COL_LO]}} & item_q.col_lo_cmd)
                   | ({8{pick[SLOT_DATA]}}   & item_q.pixel)
                   | ({8{pick[SLOT_DONE]}}   & CMD_DISPLAY_ON);
    res_d.is_data   = pick[SLOT_DATA];
    res_d.area_done = pick[SLOT_DONE];
    res_d.last      = final_slot;

    item_d = item_q;
    if (take) item_d.slots = rest;
    if (in_accept) item_d = item_i;

    res_valid_d = res_load ? item_busy : res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      item_q      <= item_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

FILE: verif/tb.sv
module tb;
  import lpaw_pkg::*;

  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int RANDOM_ITEMS    = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'hF;
  localparam result_t NO_RES = '0;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;

  // one line of the directed table: a register write or a pixel item,
  // with the controller bytes typed in when n_exp is nonzero
  typedef struct packed {
    row_kind_e      kind;
    logic [3:0]     idx;
    logic [7:0]     val;
    logic [2:0]     n_exp;
    result_t [0:5]  exp;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lcd_page_area_writer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // area model: register copy and the column / page counters
  cfg_t       disp_cfg;
  logic [7:0] col_pos;
  logic [3:0] page_pos;

  row_t    table_rows[$];
  row_t    pixels_in_flight[$];
  result_t ctrl_bytes_due[$];

  int  errors = 0;
  int  n_pixels = 0;
  int  n_bytes = 0;
  int  n_areas = 0;
  int  n_writes = 0;
  int  stuck = 0;
  bit  calm = 1'b0;

  function automatic result_t res(input logic [7:0] b, input logic d, input logic dn,
                                  input logic l);
    result_t r;
    r.out_byte  = b;
    r.is_data   = d;
    r.area_done = dn;
    r.last      = l;
    return r;
  endfunction

  function automatic int eff_width(input logic [7:0] v);
    if (v == 0) return 1;
    if (v > SCREEN_COLUMNS) return SCREEN_COLUMNS;
    return int'(v);
  endfunction

  function automatic int eff_pages(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > SCREEN_PAGES) return SCREEN_PAGES;
    return int'(v);
  endfunction

  // items still needed to reach the closing 0xaf under the given settings
  function automatic int items_to_close(input cfg_t c);
    int w, p, cp, pp;
    w  = eff_width(c.area_width);
    p  = eff_pages(c.area_pages);
    cp = (col_pos < w) ? int'(col_pos) : w - 1;
    pp = (page_pos < p) ? int'(page_pos) : p - 1;
    return (p - pp) * w - cp;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(1, 6));
    if (r < 70) return 8'd0;
    if (r < 80) return 8'($urandom_range(128, 255));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_pages();
    logic [7:0] v;
    int r;
    v = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) v[3:0] = 4'($urandom_range(1, 3));
    else if (r < 70) v[3:0] = 4'd0;
    else if (r < 80) v[3:0] = 4'($urandom_range(8, 15));
    return v;
  endfunction

  // controller bytes caused by one pixel item; advances the counters
  task automatic predict_ctrl_bytes(input logic [7:0] pix, input bit keep);
    result_t    seq [6];
    logic [3:0] page_addr;
    int         n, w, p;
    w = eff_width(disp_cfg.area_width);
    p = eff_pages(disp_cfg.area_pages);
    n = 0;
    if (col_pos == 0) begin
      if (page_pos == 0) begin
        seq[n] = res(CMD_START_LINE, 1'b0, 1'b0, 1'b0);
        n++;
      end
      // page address wraps inside the low nibble
      page_addr = disp_cfg.start_page + page_pos;
      seq[n] = res(CMD_PAGE_ADDR + page_addr, 1'b0, 1'b0, 1'b0);
      seq[n+1] = res(CMD_COL_HIGH + disp_cfg.start_column[6:4], 1'b0, 1'b0, 1'b0);
      seq[n+2] = res(CMD_COL_LOW + disp_cfg.start_column[3:0], 1'b0, 1'b0, 1'b0);
      n += 3;
    end
    seq[n] = res(pix, 1'b1, 1'b0, 1'b0);
    n++;
    if (col_pos + 1 >= w) begin
      col_pos = '0;
      if (page_pos + 1 >= p) begin
        page_pos = '0;
        seq[n] = res(CMD_DISPLAY_ON, 1'b0, 1'b1, 1'b0);
        n++;
      end else begin
        page_pos = page_pos + 4'd1;
      end
    end else begin
      col_pos = col_pos + 8'd1;
    end
    seq[n-1].last = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) ctrl_bytes_due.push_back(seq[k]);
    end
  endtask

  always @(posedge clk) begin : monitor
    row_t    px;
    result_t got, want;
    if (!rst_n) begin
      disp_cfg.area_width   = 8'd128;
      disp_cfg.area_pages   = 4'd8;
      disp_cfg.start_page   = '0;
      disp_cfg.start_column = '0;
      col_pos  = '0;
      page_pos = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        px = pixels_in_flight.pop_front();
        n_pixels++;
        if (px.n_exp != 0) begin
          for (int k = 0; k < px.n_exp; k++) ctrl_bytes_due.push_back(px.exp[k]);
          predict_ctrl_bytes(s_tdata, 1'b0);
        end else begin
          predict_ctrl_bytes(s_tdata, 1'b1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        case (cfg_index)
          CFG_AREA_WIDTH:   disp_cfg.area_width   = cfg_data;
          CFG_AREA_PAGES:   disp_cfg.area_pages   = cfg_data[3:0];
          CFG_START_PAGE:   disp_cfg.start_page   = cfg_data[2:0];
          CFG_START_COLUMN: disp_cfg.start_column = cfg_data[6:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.out_byte  = m_tdata;
        got.is_data   = m_tuser[0];
        got.area_done = m_tuser[1];
        got.last      = m_tlast;
        if (ctrl_bytes_due.size() == 0) begin
          $display("%0t: unexpected output item, got %h", $time, got);
          errors++;
        end else begin
          want = ctrl_bytes_due.pop_front();
          n_bytes++;
          if (want.area_done) n_areas++;
          if (got.out_byte != want.out_byte) begin
            $display("%0t: out_byte expected %h got %h", $time, want.out_byte, got.out_byte);
            errors++;
          end
          if (got.is_data != want.is_data) begin
            $display("%0t: is_data expected %b got %b", $time, want.is_data, got.is_data);
            errors++;
          end
          if (got.area_done != want.area_done) begin
            $display("%0t: area_done expected %b got %b", $time, want.area_done,
                     got.area_done);
            errors++;
          end
          if (got.last != want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck == WATCHDOG_CYCLES) begin
      $display("%0t: no handshake for %0d cycles, %0d bytes still due", $time,
               WATCHDOG_CYCLES, ctrl_bytes_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side backpressure
  initial begin : sink_stall
    int run, g;
    forever begin
      run = $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic add_row(input row_kind_e k, input logic [3:0] i, input logic [7:0] v,
                         input int n, input result_t [0:5] e);
    row_t r;
    r.kind  = k;
    r.idx   = i;
    r.val   = v;
    r.n_exp = 3'(n);
    r.exp   = e;
    table_rows.push_back(r);
  endtask

  // valid stays high on return; the caller lowers it
  task automatic push_pixel(input row_t r);
    pixels_in_flight.push_back(r);
    s_tvalid <= 1'b1;
    s_tdata  <= r.val;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait until every byte has come out, then let the block settle
  task automatic quiesce();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (ctrl_bytes_due.size() != 0 || pixels_in_flight.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    row_t      r;
    row_kind_e prev;
    cfg_t      next;
    logic [7:0] v;
    int n, w, cp, plain_items, settings_used;
    bit wide_done;

    // full screen after reset
    add_row(ROW_PIX, '0, 8'h00, 5, {res(CMD_START_LINE, 0, 0, 0), res(CMD_PAGE_ADDR, 0, 0, 0),
            res(CMD_COL_HIGH, 0, 0, 0), res(CMD_COL_LOW, 0, 0, 0), res(8'h00, 1, 0, 1),
            NO_RES});
    add_row(ROW_PIX, '0, 8'hFF, 0, '0);
    // one by one area at the far corner, set while the full screen is under way
    add_row(ROW_REG, CFG_AREA_WIDTH, 8'd1, 0, '0);
    add_row(ROW_REG, CFG_AREA_PAGES, 8'd1, 0, '0);
    add_row(ROW_REG, CFG_START_PAGE, 8'd7, 0, '0);
    add_row(ROW_REG, CFG_START_COLUMN, 8'h7F, 0, '0);
    add_row(ROW_PIX, '0, 8'h5A, 0, '0);
    add_row(ROW_PIX, '0, 8'h81, 6, {res(CMD_START_LINE, 0, 0, 0),
            res(CMD_PAGE_ADDR + 8'h07, 0, 0, 0), res(CMD_COL_HIGH + 8'h07, 0, 0, 0),
            res(CMD_COL_LOW + 8'h0F, 0, 0, 0), res(8'h81, 1, 0, 0),
            res(CMD_DISPLAY_ON, 0, 1, 1)});
    // zero width and zero pages act as one; unused data bits are dropped
    add_row(ROW_REG, CFG_AREA_WIDTH, 8'd0, 0, '0);
    add_row(ROW_REG, CFG_AREA_PAGES, 8'hF0, 0, '0);
    add_row(ROW_REG, CFG_START_PAGE, 8'hF8, 0, '0);
    add_row(ROW_REG, CFG_START_COLUMN, 8'h80, 0, '0);
    add_row(ROW_PIX, '0, 8'h3C, 6, {res(CMD_START_LINE, 0, 0, 0), res(CMD_PAGE_ADDR, 0, 0, 0),
            res(CMD_COL_HIGH, 0, 0, 0), res(CMD_COL_LOW, 0, 0, 0), res(8'h3C, 1, 0, 0),
            res(CMD_DISPLAY_ON, 0, 1, 1)});
    // page count above the screen clamps to eight, page address runs past 7
    add_row(ROW_REG, CFG_AREA_WIDTH, 8'd2, 0, '0);
    add_row(ROW_REG, CFG_AREA_PAGES, 8'h0F, 0, '0);
    add_row(ROW_REG, CFG_START_PAGE, 8'd7, 0, '0);
    add_row(ROW_REG, CFG_START_COLUMN, 8'h15, 0, '0);
    for (int k = 0; k < 16; k++) begin
      v = (k < 8) ? (8'h01 << k) : ~(8'h01 << (k - 8));
      add_row(ROW_PIX, '0, v, 0, '0);
    end
    add_row(ROW_REG, CFG_UNUSED_IDX, 8'hFF, 0, '0);
    add_row(ROW_REG, CFG_START_COLUMN, 8'h70, 0, '0);
    add_row(ROW_REG, CFG_AREA_WIDTH, 8'd1, 0, '0);
    add_row(ROW_REG, CFG_AREA_PAGES, 8'd2, 0, '0);
    add_row(ROW_PIX, '0, 8'hAA, 0, '0);
    add_row(ROW_PIX, '0, 8'h55, 0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev = ROW_PIX;
    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_REG) begin
        if (prev == ROW_PIX) quiesce();
        write_reg(table_rows[i].idx, table_rows[i].val);
      end else begin
        if (prev == ROW_REG) cfg_valid <= 1'b0;
        push_pixel(table_rows[i]);
        idle_gap();
      end
      prev = table_rows[i].kind;
    end

    plain_items   = 0;
    settings_used = 0;
    wide_done     = 1'b0;
    r.kind  = ROW_PIX;
    r.idx   = '0;
    r.n_exp = '0;
    r.exp   = '0;
    while (plain_items < RANDOM_ITEMS) begin
      quiesce();
      calm = ($urandom_range(0, 4) == 0);
      next = disp_cfg;
      if (!wide_done && plain_items >= 30) begin
        // one full-width page: width at or above the screen, single page
        v = $urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(129, 255));
        write_reg(CFG_AREA_WIDTH, v);
        w = eff_width(v);
        v = 8'($urandom);
        v[3:0] = 4'($urandom_range(0, 1));
        write_reg(CFG_AREA_PAGES, v);
        cp = (col_pos < w) ? int'(col_pos) : w - 1;
        n = w - cp + 2;
        wide_done = 1'b1;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          v = pick_width();
          write_reg(CFG_AREA_WIDTH, v);
          next.area_width = v;
        end
        if ($urandom_range(0, 3) != 0) begin
          v = pick_pages();
          write_reg(CFG_AREA_PAGES, v);
          next.area_pages = v[3:0];
        end
        if ($urandom_range(0, 3) != 0) begin
          v = 8'($urandom);
          write_reg(CFG_START_PAGE, v);
          next.start_page = v[2:0];
        end
        if ($urandom_range(0, 3) != 0) begin
          v = 8'($urandom);
          write_reg(CFG_START_COLUMN, v);
          next.start_column = v[6:0];
        end
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED_IDX, 8'($urandom));
        // mostly run areas to their close, sometimes stop mid-area
        if ($urandom_range(0, 2) != 0) begin
          n = items_to_close(next);
          if ($urandom_range(0, 1) == 1)
            n += eff_width(next.area_width) * eff_pages(next.area_pages);
        end else begin
          n = $urandom_range(1, 20);
        end
        if (n > 40) n = $urandom_range(1, 40);
      end
      cfg_valid <= 1'b0;
      for (int k = 0; k < n; k++) begin
        r.val = rand_pixel();
        push_pixel(r);
        idle_gap();
      end
      plain_items += n;
      settings_used++;
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d pixel items, %0d controller bytes checked, %0d areas closed",
             n_pixels, n_bytes, n_areas);
    $display("%0d register writes over %0d random settings, incl. clamped and zero sizes",
             n_writes, settings_used);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
